>>> rtl/hbfm_pkg.sv
package hbfm_pkg;

   // Reset values of the control registers
   localparam logic [7:0] MISS_TIMEOUT_RESET = 8'd15;
   localparam logic [3:0] TAKEOVER_RESET     = 4'd2;

   // Missed count saturates here
   localparam logic [3:0] MISS_COUNT_MAX = 4'd15;

   // Item kinds
   localparam logic KIND_HEARTBEAT = 1'b0;
   localparam logic KIND_CHECK     = 1'b1;

   // Control register indexes
   localparam logic CSR_MISS_TIMEOUT = 1'b0;
   localparam logic CSR_TAKEOVER     = 1'b1;

   // Result codes
   localparam logic [1:0] RC_OK          = 2'd0;
   localparam logic [1:0] RC_BAD_CLUSTER = 2'd1;
   localparam logic [1:0] RC_TABLE_FULL  = 2'd2;
   localparam logic [1:0] RC_NO_MASTER   = 2'd3;

   // Table update broadcast to every cell after a search or at a check tick
   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_CHECK    = 3'd1,
      OP_INSERT   = 3'd2,
      OP_REFRESH  = 3'd3,
      OP_TAKEOVER = 3'd4
   } op_type;

   // Search beat that walks the cell row, one cell per cycle
   typedef struct packed {
      logic        active;
      logic [2:0]  cluster;
      logic        node_type;
      logic [15:0] server_id;
      logic        node_hit;
      logic        node_is_master;
      logic        master_hit;
      logic        master_missed;
      logic [3:0]  master_count;
      logic        free_hit;
   } beat_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  cluster;
      logic        node_type;
      logic [15:0] server_id;
      logic [31:0] now;
      logic        new_master;
   } commit_type;

endpackage

>>> rtl/hbfm_cell.sv
module hbfm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  hbfm_pkg::beat_type     beat_in,
   output hbfm_pkg::beat_type     beat_out,
   input  hbfm_pkg::commit_type   commit,
   input  logic [7:0]             miss_timeout
);
   import hbfm_pkg::*;

   // Entry storage
   logic        valid_ff, valid_in;
   logic [2:0]  cluster_ff, cluster_in;
   logic        type_ff, type_in;
   logic [15:0] id_ff, id_in;
   logic        master_ff, master_in;
   logic [31:0] seen_ff, seen_in;
   logic        missed_ff, missed_in;
   logic [3:0]  count_ff, count_in;

   // Which role this cell took in the last search
   logic node_sel_ff, master_sel_ff, free_sel_ff;

   beat_type beat_ff, beat_in_next;

   logic        match;
   logic        node_here;
   logic        master_here;
   logic        free_here;
   logic [31:0] age;
   logic        stale;

   // Search: first match of node, first master, first free slot
   assign match       = valid_ff && (cluster_ff == beat_in.cluster)
                        && (type_ff == beat_in.node_type);
   assign node_here   = match && (id_ff == beat_in.server_id) && !beat_in.node_hit;
   assign master_here = match && master_ff && !beat_in.master_hit;
   assign free_here   = !valid_ff && !beat_in.free_hit;

   always_comb begin
      beat_in_next = beat_in;
      if (node_here) begin
         beat_in_next.node_hit       = 1'b1;
         beat_in_next.node_is_master = master_ff;
      end
      if (master_here) begin
         beat_in_next.master_hit    = 1'b1;
         beat_in_next.master_missed = missed_ff;
         beat_in_next.master_count  = count_ff;
      end
      if (free_here) begin
         beat_in_next.free_hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in_next;
      end
   end

   assign beat_out = beat_ff;

   always_ff @(posedge clock) begin
      if (beat_in.active) begin
         node_sel_ff   <= node_here;
         master_sel_ff <= master_here;
         free_sel_ff   <= free_here;
      end
   end

   // Aging at a check tick, modulo 2^32
   assign age   = commit.now - seen_ff;
   assign stale = age > {24'd0, miss_timeout};

   // Commit of the broadcast update
   always_comb begin
      valid_in   = valid_ff;
      cluster_in = cluster_ff;
      type_in    = type_ff;
      id_in      = id_ff;
      master_in  = master_ff;
      seen_in    = seen_ff;
      missed_in  = missed_ff;
      count_in   = count_ff;
      unique case (commit.op)
         OP_NONE: begin
         end
         OP_CHECK: begin
            if (valid_ff) begin
               if (stale) begin
                  missed_in = 1'b1;
                  if (count_ff != MISS_COUNT_MAX) begin
                     count_in = count_ff + 4'd1;
                  end
               end else begin
                  count_in = 4'd0;
               end
            end
         end
         OP_INSERT: begin
            if (free_sel_ff) begin
               valid_in   = 1'b1;
               cluster_in = commit.cluster;
               type_in    = commit.node_type;
               id_in      = commit.server_id;
               master_in  = commit.new_master;
               seen_in    = commit.now;
               missed_in  = 1'b0;
               count_in   = 4'd0;
            end
         end
         OP_REFRESH: begin
            if (node_sel_ff) begin
               seen_in   = commit.now;
               missed_in = 1'b0;
               if (master_ff) begin
                  count_in = 4'd0;
               end
            end
         end
         OP_TAKEOVER: begin
            if (node_sel_ff) begin
               seen_in   = commit.now;
               missed_in = 1'b0;
               master_in = 1'b1;
            end else if (master_sel_ff) begin
               master_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cluster_ff <= cluster_in;
      type_ff    <= type_in;
      id_ff      <= id_in;
      master_ff  <= master_in;
      seen_ff    <= seen_in;
      missed_ff  <= missed_in;
      count_ff   <= count_in;
   end

endmodule

>>> rtl/heartbeat_failover_monitor.sv
// Heartbeat master/standby failover monitor. The node table is a row of TABLE_DEPTH
// cells, one entry per cell. A heartbeat launches a search beat that walks the row one
// cell per cycle, picking up the sender's entry, the master of its cluster and type and
// the lowest free slot; the table update is then broadcast to all cells. A heartbeat
// with a bad cluster number is answered without a search, and a check tick broadcasts
// its update and gives no result. One item is in work at a time; a new item is stalled
// until the previous result beat has been taken.
module heartbeat_failover_monitor #(
   parameter int TABLE_DEPTH  = 16,
   parameter int NUM_CLUSTERS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_now_seconds,
   input  logic [2:0]  req_cluster_number,
   input  logic        req_node_type,
   input  logic [15:0] req_server_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ack_status,
   output logic        rsp_reconnect,
   output logic        rsp_promoted,
   output logic [1:0]  rsp_result_code,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);
   import hbfm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type  state_ff, state_in;
   beat_type   head_ff, head_in;
   commit_type commit_ff, commit_in;
   logic [31:0] now_ff, now_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ack_ff, ack_in;
   logic       reconnect_ff, reconnect_in;
   logic       promoted_ff, promoted_in;
   logic [1:0] code_ff, code_in;

   logic [7:0] miss_timeout_ff;
   logic [3:0] takeover_ff;

   beat_type chain [TABLE_DEPTH+1];
   beat_type tail;
   logic     req_accept;
   logic     bad_cluster;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_timeout_ff <= MISS_TIMEOUT_RESET;
         takeover_ff     <= TAKEOVER_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MISS_TIMEOUT: miss_timeout_ff <= csr_write_data;
            CSR_TAKEOVER:     takeover_ff     <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Cell row
   assign chain[0] = head_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      hbfm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .beat_in      (chain[g]),
         .beat_out     (chain[g+1]),
         .commit       (commit_ff),
         .miss_timeout (miss_timeout_ff)
      );
   end

   assign tail = chain[TABLE_DEPTH];

   assign req_stall   = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_accept  = req_valid && !req_stall;
   assign bad_cluster = (req_cluster_number == 3'd0)
                        || (req_cluster_number > 3'(NUM_CLUSTERS));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = '0;
      commit_in    = '0;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ack_in       = ack_ff;
      reconnect_in = reconnect_ff;
      promoted_in  = promoted_ff;
      code_in      = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               now_in = req_now_seconds;
               if (req_kind == KIND_CHECK) begin
                  commit_in.op  = OP_CHECK;
                  commit_in.now = req_now_seconds;
                  state_in      = ST_COMMIT;
               end else if (bad_cluster) begin
                  rsp_valid_in = 1'b1;
                  ack_in       = 1'b0;
                  reconnect_in = 1'b0;
                  promoted_in  = 1'b0;
                  code_in      = RC_BAD_CLUSTER;
               end else begin
                  head_in.active    = 1'b1;
                  head_in.cluster   = req_cluster_number;
                  head_in.node_type = req_node_type;
                  head_in.server_id = req_server_id;
                  state_in          = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tail.active) begin
               commit_in.cluster    = tail.cluster;
               commit_in.node_type  = tail.node_type;
               commit_in.server_id  = tail.server_id;
               commit_in.now        = now_ff;
               commit_in.new_master = !tail.master_hit;
               rsp_valid_in         = 1'b1;
               promoted_in          = 1'b0;
               code_in              = RC_OK;
               state_in             = ST_COMMIT;
               if (!tail.node_hit) begin
                  reconnect_in = 1'b0;
                  if (!tail.free_hit) begin
                     ack_in  = 1'b0;
                     code_in = RC_TABLE_FULL;
                  end else begin
                     commit_in.op = OP_INSERT;
                     ack_in       = !tail.master_hit;
                  end
               end else begin
                  reconnect_in = 1'b1;
                  ack_in       = 1'b1;
                  commit_in.op = OP_REFRESH;
                  if (!tail.node_is_master) begin
                     if (!tail.master_hit) begin
                        code_in = RC_NO_MASTER;
                     end else if (tail.master_missed
                                  && (tail.master_count >= takeover_ff)) begin
                        commit_in.op = OP_TAKEOVER;
                        ack_in       = 1'b0;
                        promoted_in  = 1'b1;
                     end
                  end
               end
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         commit_ff    <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ack_ff       <= 1'b0;
         reconnect_ff <= 1'b0;
         promoted_ff  <= 1'b0;
         code_ff      <= RC_OK;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         commit_ff    <= commit_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         ack_ff       <= ack_in;
         reconnect_ff <= reconnect_in;
         promoted_ff  <= promoted_in;
         code_ff      <= code_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ack_status  = ack_ff;
   assign rsp_reconnect   = reconnect_ff;
   assign rsp_promoted    = promoted_ff;
   assign rsp_result_code = code_ff;

`ifndef SYNTH
   // The search beat leaves the row only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == ST_SCAN))
      else $error("search beat left the row outside the scan");

   // Every accepted item either starts work or answers at once
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ((state_ff != ST_IDLE) || rsp_valid_ff))
      else $error("accepted item was dropped");

   // An update is broadcast for a single cycle
   assert property (@(posedge clock) disable iff (reset)
      (commit_ff.op != OP_NONE) |=> (commit_ff.op == OP_NONE))
      else $error("table update repeated");

   // Only a known standby can be promoted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_promoted) |-> (rsp_reconnect && !rsp_ack_status))
      else $error("promotion of an unknown node");
`endif

endmodule

>>> dv/tb_top.sv
module tb_top;
   import hbfm_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int NUM_CLUSTERS = 3;
   localparam int RANDOM_PHASES    = 5;
   localparam int ITEMS_PER_PHASE  = 150;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int POOL_SIZE        = 20;

   typedef struct packed {
      logic        kind;
      logic [31:0] now;
      logic [2:0]  cluster;
      logic        node_type;
      logic [15:0] server_id;
   } hb_item_type;

   typedef struct packed {
      logic       ack_status;
      logic       reconnect;
      logic       promoted;
      logic [1:0] result_code;
   } reply_type;

   typedef struct packed {
      hb_item_type item;
      logic        typed;
      reply_type   want;
   } stim_row_type;

   typedef struct packed {
      logic [2:0]  cluster;
      logic        node_type;
      logic [15:0] server_id;
   } node_key_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [31:0] req_now_seconds = '0;
   logic [2:0]  req_cluster_number = '0;
   logic        req_node_type = 1'b0;
   logic [15:0] req_server_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ack_status;
   logic        rsp_reconnect;
   logic        rsp_promoted;
   logic [1:0]  rsp_result_code;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_write_data = '0;

   heartbeat_failover_monitor #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUM_CLUSTERS(NUM_CLUSTERS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_now_seconds   (req_now_seconds),
      .req_cluster_number(req_cluster_number),
      .req_node_type     (req_node_type),
      .req_server_id     (req_server_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ack_status    (rsp_ack_status),
      .rsp_reconnect     (rsp_reconnect),
      .rsp_promoted      (rsp_promoted),
      .rsp_result_code   (rsp_result_code),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Shadow copy of the node table and control registers
   logic [7:0]  shadow_timeout  = MISS_TIMEOUT_RESET;
   logic [3:0]  shadow_takeover = TAKEOVER_RESET;
   logic        node_valid[TABLE_DEPTH] = '{default: 1'b0};
   logic [2:0]  node_cluster[TABLE_DEPTH];
   logic        node_kind[TABLE_DEPTH];
   logic [15:0] node_id[TABLE_DEPTH];
   logic        node_master[TABLE_DEPTH];
   logic [31:0] node_seen[TABLE_DEPTH];
   logic        node_missed[TABLE_DEPTH];
   logic [3:0]  node_misses[TABLE_DEPTH];

   reply_type    pending_replies[$];
   stim_row_type directed_rows[$];
   node_key_type node_pool[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   logic long_hold_wanted = 1'b0;
   logic long_hold_done = 1'b0;
   logic no_idle = 1'b0;

   // Table update for one item; returns 1 when the item produces a reply beat
   function automatic logic predict_reply(input hb_item_type it, output reply_type r);
      int          hit;
      int          master;
      int          free_slot;
      logic [31:0] age;
      r = '0;
      hit = -1;
      master = -1;
      free_slot = -1;
      if (it.kind == KIND_CHECK) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (node_valid[i]) begin
               age = it.now - node_seen[i];
               if (age > {24'd0, shadow_timeout}) begin
                  if (node_misses[i] != MISS_COUNT_MAX)
                     node_misses[i] = node_misses[i] + 4'd1;
                  node_missed[i] = 1'b1;
               end else begin
                  node_misses[i] = 4'd0;
               end
            end
         end
         return 1'b0;
      end
      if (it.cluster == 3'd0 || it.cluster > NUM_CLUSTERS) begin
         r.result_code = RC_BAD_CLUSTER;
         return 1'b1;
      end
      // lowest-index search for the sender, the group master and a free slot
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!node_valid[i]) begin
            if (free_slot < 0)
               free_slot = i;
         end else if (node_cluster[i] == it.cluster && node_kind[i] == it.node_type) begin
            if (hit < 0 && node_id[i] == it.server_id)
               hit = i;
            if (master < 0 && node_master[i])
               master = i;
         end
      end
      if (hit < 0) begin
         if (free_slot < 0) begin
            r.result_code = RC_TABLE_FULL;
            return 1'b1;
         end
         node_valid[free_slot]   = 1'b1;
         node_cluster[free_slot] = it.cluster;
         node_kind[free_slot]    = it.node_type;
         node_id[free_slot]      = it.server_id;
         node_master[free_slot]  = (master < 0);
         node_seen[free_slot]    = it.now;
         node_missed[free_slot]  = 1'b0;
         node_misses[free_slot]  = 4'd0;
         r.ack_status = (master < 0);
         r.result_code = RC_OK;
         return 1'b1;
      end
      node_seen[hit] = it.now;
      node_missed[hit] = 1'b0;
      r.reconnect = 1'b1;
      if (node_master[hit]) begin
         node_misses[hit] = 4'd0;
         r.ack_status = 1'b1;
      end else if (master < 0) begin
         r.ack_status = 1'b1;
         r.result_code = RC_NO_MASTER;
      end else if (node_missed[master] && node_misses[master] >= shadow_takeover) begin
         node_master[master] = 1'b0;
         node_master[hit] = 1'b1;
         r.promoted = 1'b1;
      end else begin
         r.ack_status = 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic add_row(input logic kind, input logic [31:0] now, input logic [2:0] cl,
                          input logic ty, input logic [15:0] id, input logic typed,
                          input reply_type want);
      stim_row_type row;
      row.item = '{kind, now, cl, ty, id};
      row.typed = typed;
      row.want = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one request beat, hold it until taken, then record its reply
   task automatic send_item(input hb_item_type it, input logic typed, input reply_type want);
      reply_type predicted;
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_kind           = it.kind;
      req_now_seconds    = it.now;
      req_cluster_number = it.cluster;
      req_node_type      = it.node_type;
      req_server_id      = it.server_id;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (predict_reply(it, predicted))
         pending_replies.insert(pending_replies.size(), typed ? want : predicted);
   endtask

   // Quiet the sender and let every reply and any trailing check finish
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_MISS_TIMEOUT)
         shadow_timeout = data;
      else
         shadow_takeover = data[3:0];
   endtask

   // Clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("heartbeat_failover_monitor: mismatch");
         $finish;
      end
   end

   // Receiver stall: random idling, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_wanted && !long_hold_done) begin
         hold_left = LONG_HOLD_CYCLES;
         long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = !no_idle && ($urandom_range(0, 99) < 21);
      end
   end

   // Compare each reply beat with the oldest expectation
   always @(posedge clock) begin
      reply_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply beat: ack %0b rec %0b prom %0b code %0d",
                        rsp_ack_status, rsp_reconnect, rsp_promoted, rsp_result_code);
         end else begin
            exp_r = pending_replies.pop_front();
            if (rsp_ack_status !== exp_r.ack_status || rsp_reconnect !== exp_r.reconnect ||
                rsp_promoted !== exp_r.promoted || rsp_result_code !== exp_r.result_code) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"reply mismatch: expected ack %0b rec %0b prom %0b code %0d,",
                            " got ack %0b rec %0b prom %0b code %0d"},
                           exp_r.ack_status, exp_r.reconnect, exp_r.promoted,
                           exp_r.result_code, rsp_ack_status, rsp_reconnect,
                           rsp_promoted, rsp_result_code);
            end
         end
      end
   end

   // Stimulus
   initial begin
      reply_type    none;
      reply_type    bad_cluster;
      hb_item_type  it;
      node_key_type key;
      logic [31:0]  clock_now;
      int           pick;
      none = '0;
      bad_cluster = '{1'b0, 1'b0, 1'b0, RC_BAD_CLUSTER};
      clock_now = 32'd1000;

      // directed: bad clusters, first inserts, refresh, takeover, time wrap
      add_row(KIND_HEARTBEAT, 32'd0,          3'd0, 1'b0, 16'h0000, 1'b1, bad_cluster);
      add_row(KIND_HEARTBEAT, 32'hFFFF_FFFF,  3'd7, 1'b1, 16'hFFFF, 1'b1, bad_cluster);
      add_row(KIND_HEARTBEAT, 32'd50,         3'd4, 1'b0, 16'h0001, 1'b1, bad_cluster);
      add_row(KIND_HEARTBEAT, 32'd100, 3'd1, 1'b0, 16'h0000, 1'b1, '{1'b1, 1'b0, 1'b0, RC_OK});
      add_row(KIND_HEARTBEAT, 32'd100, 3'd1, 1'b0, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 1'b0, RC_OK});
      add_row(KIND_HEARTBEAT, 32'd101, 3'd1, 1'b1, 16'h0000, 1'b1, '{1'b1, 1'b0, 1'b0, RC_OK});
      add_row(KIND_HEARTBEAT, 32'd102, 3'd3, 1'b1, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 1'b0, RC_OK});
      add_row(KIND_HEARTBEAT, 32'd103, 3'd2, 1'b0, 16'h1234, 1'b1, '{1'b1, 1'b0, 1'b0, RC_OK});
      add_row(KIND_HEARTBEAT, 32'd105, 3'd1, 1'b0, 16'h0000, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd105, 3'd1, 1'b0, 16'hFFFF, 1'b0, none);
      add_row(KIND_CHECK,     32'd200, 3'd5, 1'b1, 16'hABCD, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd201, 3'd1, 1'b0, 16'hFFFF, 1'b0, none);
      add_row(KIND_CHECK,     32'd300, 3'd0, 1'b0, 16'h0000, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd301, 3'd1, 1'b0, 16'hFFFF, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd302, 3'd1, 1'b0, 16'h0000, 1'b0, none);
      add_row(KIND_CHECK,     32'd5,   3'd7, 1'b1, 16'hFFFF, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd6,   3'd1, 1'b0, 16'h0000, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'hFFFF_FFFF, 3'd3, 1'b1, 16'hFFFF, 1'b0, none);
      add_row(KIND_CHECK,     32'd0,   3'd2, 1'b0, 16'h5555, 1'b0, none);
      add_row(KIND_HEARTBEAT, 32'd0,   3'd2, 1'b1, 16'h5A5A, 1'b0, none);

      // pool of known senders plus fresh ones, enough to overflow the table
      node_pool.insert(node_pool.size(), '{3'd1, 1'b0, 16'h0000});
      node_pool.insert(node_pool.size(), '{3'd1, 1'b0, 16'hFFFF});
      node_pool.insert(node_pool.size(), '{3'd1, 1'b1, 16'h0000});
      node_pool.insert(node_pool.size(), '{3'd3, 1'b1, 16'hFFFF});
      node_pool.insert(node_pool.size(), '{3'd2, 1'b0, 16'h1234});
      node_pool.insert(node_pool.size(), '{3'd2, 1'b1, 16'h5A5A});
      while (node_pool.size() < POOL_SIZE) begin
         key.cluster   = 3'($urandom_range(1, NUM_CLUSTERS));
         key.node_type = 1'($urandom_range(0, 1));
         key.server_id = 16'($urandom_range(0, 65535));
         node_pool.insert(node_pool.size(), key);
      end

      while (reset)
         @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      wait_until_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // control settings, extremes first
         case (phase)
            1: begin
               write_csr(CSR_MISS_TIMEOUT, 8'd0);
               write_csr(CSR_TAKEOVER, {4'($urandom_range(0, 15)), 4'd0});
            end
            2: begin
               write_csr(CSR_MISS_TIMEOUT, 8'd255);
               write_csr(CSR_TAKEOVER, {4'($urandom_range(0, 15)), 4'd15});
            end
            3: begin
               write_csr(CSR_MISS_TIMEOUT, 8'd3);
               write_csr(CSR_TAKEOVER, {4'($urandom_range(0, 15)), 4'd15});
            end
            4: begin
               write_csr(CSR_MISS_TIMEOUT, 8'($urandom_range(1, 40)));
               write_csr(CSR_TAKEOVER, 8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         if (phase == 2)
            long_hold_wanted = 1'b1;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            no_idle = (phase == 3 && n < 100);
            if (phase == 1 && n == ITEMS_PER_PHASE / 2)
               wait_until_idle();

            // time mostly creeps forward, now and then it jumps anywhere
            if ($urandom_range(0, 99) < 2)
               clock_now = $urandom();
            else
               clock_now = clock_now + 32'($urandom_range(0, 12));

            it.now       = clock_now;
            it.kind      = KIND_HEARTBEAT;
            it.cluster   = 3'($urandom_range(0, 7));
            it.node_type = 1'($urandom_range(0, 1));
            it.server_id = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               it.kind = KIND_CHECK;
            end else if (pick < 36) begin
               it.cluster = ($urandom_range(0, 4) == 0) ? 3'd0
                          : 3'($urandom_range(NUM_CLUSTERS + 1, 7));
            end else if (pick < 40) begin
               it.cluster = 3'($urandom_range(1, NUM_CLUSTERS));
            end else begin
               // skewed choice: late pool entries heartbeat rarely and go stale
               key = node_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
               it.cluster   = key.cluster;
               it.node_type = key.node_type;
               it.server_id = key.server_id;
            end
            send_item(it, 1'b0, none);
         end
         no_idle = 1'b0;
         wait_until_idle();
      end

      if (mismatch_count == 0)
         $display("heartbeat_failover_monitor: match");
      else
         $display("heartbeat_failover_monitor: mismatch");
      $finish;
   end

endmodule
